// ----- sv/error_function_approx_macros.svh -----
// Assertion macros for the error function block checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ERROR_FUNCTION_APPROX_MACROS_SVH
`define ERROR_FUNCTION_APPROX_MACROS_SVH

// Check on every clock edge outside reset.
`define EFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check on every clock edge, reset included.
`define EFA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ----- sv/efa_pkg.sv -----
// Shared constants, widths and pipeline latencies of the error function block.
// No dependencies; the files that use it refer to it by scoped names.
`default_nettype none

package efa_pkg;

  // Datapath widths (internal fixed point is Q30)
  localparam int unsigned QF     = 30;
  localparam int unsigned MAG_W  = 17;  // |x| up to 2^15
  localparam int unsigned PXP_W  = 46;  // |x| * P before rounding
  localparam int unsigned SQ_W   = 31;  // |x|^2
  localparam int unsigned YF_W   = 46;  // x^2 in Q30 before range check
  localparam int unsigned Y_W    = 35;  // x^2 in Q30 below 24
  localparam int unsigned DEN_W  = 38;  // 1 + p|x| in Q30
  localparam int unsigned T_W    = 31;  // t in Q30, at most 1.0
  localparam int unsigned ACC_W  = 34;  // signed Horner accumulator
  localparam int unsigned S_W    = 33;  // clamped polynomial value
  localparam int unsigned E_W    = 31;  // exp(-x^2) in Q30
  localparam int unsigned OUT_W  = 16;

  localparam logic [OUT_W-1:0] SAT_MAX = 16'd32767;

  // Q30 constants, rounded to nearest; log2(e) is held in Q28
  localparam logic [28:0] K_P =
    29'(((64'd3275911 << 30) + 64'd5000000) / 64'd10000000);
  localparam logic signed [ACC_W-1:0] K_A1 =
    ACC_W'(((64'd254829592 << 30) + 64'd500000000) / 64'd1000000000);
  localparam logic signed [ACC_W-1:0] K_A2 =
    -ACC_W'(((64'd284496736 << 30) + 64'd500000000) / 64'd1000000000);
  localparam logic signed [ACC_W-1:0] K_A3 =
    ACC_W'(((64'd1421413741 << 30) + 64'd500000000) / 64'd1000000000);
  localparam logic signed [ACC_W-1:0] K_A4 =
    -ACC_W'(((64'd1453152027 << 30) + 64'd500000000) / 64'd1000000000);
  localparam logic signed [ACC_W-1:0] K_A5 =
    ACC_W'(((64'd1061405429 << 30) + 64'd500000000) / 64'd1000000000);
  localparam logic [28:0] K_LOG2E_Q28 = 29'd387270501;
  localparam logic [29:0] K_LN2       = 30'd744261118;

  // Pipeline structure
  localparam int unsigned HORNER_STEPS = 5;
  localparam int unsigned EXP_TERMS    = 13;
  localparam int unsigned RECIP_LAT    = T_W;
  localparam int unsigned HORNER_LAT   = 2 * HORNER_STEPS + 1;
  localparam int unsigned EXP_LAT      = 5 + 4 * EXP_TERMS;

  // Constant added after the multiply of Horner step idx
  function automatic logic signed [ACC_W-1:0] horner_coef(input logic [2:0] idx);
    logic signed [ACC_W-1:0] c;
    unique case (idx)
      3'd0:    c = K_A4;
      3'd1:    c = K_A3;
      3'd2:    c = K_A2;
      3'd3:    c = K_A1;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- sv/efa_arg_if.sv -----
// Argument channel of the error function block: valid/ready and one Q3.12 word.
// No dependencies.
`default_nettype none

interface efa_arg_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] arg_x;

  modport source (output valid, output arg_x, input ready);
  modport sink   (input valid, input arg_x, output ready);
endinterface

`default_nettype wire

// ----- sv/efa_erf_if.sv -----
// Result channel of the error function block: valid/ready and one Q1.15 word.
// No dependencies.
`default_nettype none

interface efa_erf_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] erf_value;

  modport source (output valid, output erf_value, input ready);
  modport sink   (input valid, input erf_value, output ready);
endinterface

`default_nettype wire

// ----- sv/error_function_approx.sv -----
// erf(x) by Abramowitz-Stegun 7.1.26. Takes one signed Q3.12 argument word per
// cycle and returns erf(x) as a signed Q1.15 word saturated to +/-32767. The
// block is a single stall-able pipeline: it accepts one word every clock while
// the result side keeps up. A word crosses 3 + max(31 + 11, 57) + 4 = 64
// register stages, set by the exp(-x^2) unit whose 13-term series takes four
// stages per term. When a result waits at the output, the whole pipeline holds
// but the input register still takes one more word if it is empty.
// Depends on efa_pkg, efa_arg_if, efa_erf_if, efa_recip, efa_horner, efa_exp,
// efa_delay.
`default_nettype none

module error_function_approx #(
  parameter int unsigned IN_FRAC_BITS  = 12,
  parameter int unsigned OUT_FRAC_BITS = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  efa_arg_if.sink     arg_i,
  efa_erf_if.source   erf_o
);

  // Stage count: input, |x| products, den/y, branches, four output stages
  localparam int unsigned LA   = efa_pkg::RECIP_LAT + efa_pkg::HORNER_LAT;
  localparam int unsigned LB   = efa_pkg::EXP_LAT;
  localparam int unsigned LMAX = (LA > LB) ? LA : LB;
  localparam int unsigned NV   = 3 + LMAX + 4;

  localparam int unsigned MW  = efa_pkg::MAG_W;
  localparam int unsigned DW  = efa_pkg::DEN_W;

  // Valid bits, one per stage
  logic [NV-1:0] v_q;
  logic          en;
  logic          en0;

  // Stage 0: sign and magnitude
  logic [MW-1:0] mag_d;
  logic [MW-1:0] mag0_q;
  logic          neg0_q;

  // Stage 1: p|x| and |x|^2 products
  logic [efa_pkg::PXP_W-1:0] pxp1_q;
  logic [efa_pkg::SQ_W-1:0]  sq1_q;
  logic                      neg1_q;

  // Stage 2: denominator and x^2 in Q30
  logic [efa_pkg::PXP_W-1:0] px_sum_w;
  logic [DW-1:0]             den_d;
  logic [efa_pkg::YF_W-1:0]  yfull_w;
  logic [DW-1:0]             den2_q;
  logic [efa_pkg::Y_W-1:0]   y2_q;
  logic                      yz2_q;
  logic                      neg2_q;

  // Branch results and aligned copies
  logic [efa_pkg::T_W-1:0]   t_w;
  logic [efa_pkg::S_W-1:0]   s_w;
  logic [efa_pkg::E_W-1:0]   e_w;
  logic [efa_pkg::S_W-1:0]   s_al;
  logic [efa_pkg::E_W-1:0]   e_al;
  logic                      neg_al;

  // Output stages
  logic [63:0]                 pr_q;
  logic                        negf1_q;
  logic [34:0]                 prod_d;
  logic [34:0]                 prod_q;
  logic                        negf2_q;
  logic [30:0]                 rc_d;
  logic [30:0]                 rc_q;
  logic                        negf3_q;
  logic [30:0]                 rr_w;
  logic [efa_pkg::OUT_W-1:0]   sat_w;
  logic [efa_pkg::OUT_W-1:0]   out_d;
  logic [efa_pkg::OUT_W-1:0]   out_q;

  // Advance everything unless a result is stuck at the output; the input
  // register may also fill a bubble while the rest holds.
  assign en          = !v_q[NV-1] || erf_o.ready;
  assign en0         = en || !v_q[0];
  assign arg_i.ready = en0;
  assign erf_o.valid = v_q[NV-1];
  assign erf_o.erf_value = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en0) begin
        v_q[0] <= arg_i.valid;
      end
      if (en) begin
        v_q[NV-1:1] <= v_q[NV-2:0];
      end
    end
  end

  // Odd symmetry: work on |x|, the most negative word gives 2^15
  always_comb begin
    mag_d = arg_i.arg_x[15] ? MW'(17'h10000 - {1'b0, arg_i.arg_x})
                            : {1'b0, arg_i.arg_x};
  end

  always_ff @(posedge clk_i) begin
    if (en0) begin
      mag0_q <= mag_d;
      neg0_q <= arg_i.arg_x[15];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pxp1_q <= efa_pkg::PXP_W'(mag0_q) * efa_pkg::PXP_W'(efa_pkg::K_P);
      sq1_q  <= efa_pkg::SQ_W'(34'(mag0_q) * 34'(mag0_q));
      neg1_q <= neg0_q;
    end
  end

  // den = 1 + p|x| with p|x| rounded half up into Q30
  always_comb begin
    px_sum_w = pxp1_q + (efa_pkg::PXP_W'(1) << (IN_FRAC_BITS - 1));
    den_d    = (DW'(1) << 30) + DW'(px_sum_w >> IN_FRAC_BITS);
  end

  // x^2 into Q30: exact left shift, or rounded right shift for fine inputs
  if (2 * IN_FRAC_BITS <= 30) begin : g_sq_up
    assign yfull_w = efa_pkg::YF_W'(sq1_q) << (30 - 2 * IN_FRAC_BITS);
  end else begin : g_sq_down
    assign yfull_w = (efa_pkg::YF_W'(sq1_q)
                      + (efa_pkg::YF_W'(1) << (2 * IN_FRAC_BITS - 31)))
                     >> (2 * IN_FRAC_BITS - 30);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      den2_q <= den_d;
      y2_q   <= yfull_w[efa_pkg::Y_W-1:0];
      yz2_q  <= (yfull_w >= (efa_pkg::YF_W'(24) << 30));
      neg2_q <= neg1_q;
    end
  end

  // t = 1 / (1 + p|x|), then the polynomial in t
  efa_recip u_recip (
    .clk_i (clk_i),
    .en_i  (en),
    .den_i (den2_q),
    .t_o   (t_w)
  );

  efa_horner u_horner (
    .clk_i (clk_i),
    .en_i  (en),
    .t_i   (t_w),
    .s_o   (s_w)
  );

  // exp(-x^2), zero once x^2 reaches 24
  efa_exp u_exp (
    .clk_i  (clk_i),
    .en_i   (en),
    .y_i    (y2_q),
    .zero_i (yz2_q),
    .e_o    (e_w)
  );

  // Align the shorter branch and the sign with the longer branch
  efa_delay #(.WIDTH(efa_pkg::S_W), .DEPTH(LMAX - LA)) u_dly_s (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (s_w),
    .d_o   (s_al)
  );

  efa_delay #(.WIDTH(efa_pkg::E_W), .DEPTH(LMAX - LB)) u_dly_e (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (e_w),
    .d_o   (e_al)
  );

  efa_delay #(.WIDTH(1), .DEPTH(LMAX)) u_dly_neg (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (neg2_q),
    .d_o   (neg_al)
  );

  // r = 1 - s*e, clamp at zero, round to the output format, saturate, sign
  always_comb begin
    prod_d = 35'((pr_q + (64'd1 << 29)) >> 30);
    rc_d   = (prod_q > (35'd1 << 30)) ? '0 : 31'((35'd1 << 30) - prod_q);
  end

  if (OUT_FRAC_BITS < 30) begin : g_round
    assign rr_w = 31'((32'(rc_q) + (32'd1 << (29 - OUT_FRAC_BITS)))
                      >> (30 - OUT_FRAC_BITS));
  end else begin : g_keep
    assign rr_w = rc_q;
  end

  always_comb begin
    sat_w = (rr_w > 31'(efa_pkg::SAT_MAX)) ? efa_pkg::SAT_MAX
                                           : rr_w[efa_pkg::OUT_W-1:0];
    out_d = negf3_q ? efa_pkg::OUT_W'(-sat_w) : sat_w;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pr_q    <= 64'(s_al) * 64'(e_al);
      negf1_q <= neg_al;
      prod_q  <= prod_d;
      negf2_q <= negf1_q;
      rc_q    <= rc_d;
      negf3_q <= negf2_q;
      out_q   <= out_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/efa_delay.sv -----
// Enabled shift line that aligns payload between pipeline branches.
// No dependencies.
`default_nettype none

module efa_delay #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] d_o
);

  if (DEPTH == 0) begin : g_none
    assign d_o = d_i;
  end else begin : g_line
    logic [WIDTH-1:0] tap_q [DEPTH];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tap_q[0] <= d_i;
        for (int i = 1; i < DEPTH; i++) begin
          tap_q[i] <= tap_q[i-1];
        end
      end
    end

    assign d_o = tap_q[DEPTH-1];
  end

endmodule

`default_nettype wire

// ----- sv/efa_recip.sv -----
// Pipelined restoring divider: t = round(2^60 / den), one quotient bit per stage.
// Depends on efa_pkg.
`default_nettype none

module efa_recip (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [efa_pkg::DEN_W-1:0]    den_i,
  output logic [efa_pkg::T_W-1:0]      t_o
);

  localparam int unsigned DW = efa_pkg::DEN_W;
  localparam int unsigned TW = efa_pkg::T_W;

  logic [DW-1:0] den_q [TW];
  logic [DW-1:0] rem_q [TW];
  logic [TW-1:0] nlo_q [TW];
  logic [TW-1:0] quo_q [TW];

  for (genvar j = 0; j < TW; j++) begin : g_stage
    logic [DW-1:0] den_in;
    logic [DW-1:0] rem_in;
    logic [TW-1:0] nlo_in;
    logic [TW-1:0] quo_in;
    logic [DW:0]   sh_w;
    logic          fit_w;
    logic [DW-1:0] rem_d;
    logic [TW-1:0] quo_d;

    if (j == 0) begin : g_first
      // Numerator is 2^60 + den/2: its bits above 30 give the start remainder
      assign den_in = den_i;
      assign rem_in = (DW'(1) << 29) + (den_i >> 32);
      assign nlo_in = den_i[TW:1];
      assign quo_in = '0;
    end else begin : g_next
      assign den_in = den_q[j-1];
      assign rem_in = rem_q[j-1];
      assign nlo_in = nlo_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    always_comb begin
      sh_w  = {rem_in, nlo_in[TW-1-j]};
      fit_w = (sh_w >= {1'b0, den_in});
      rem_d = fit_w ? DW'(sh_w - {1'b0, den_in}) : sh_w[DW-1:0];
      quo_d = {quo_in[TW-2:0], fit_w};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[j] <= den_in;
        rem_q[j] <= rem_d;
        nlo_q[j] <= nlo_in;
        quo_q[j] <= quo_d;
      end
    end
  end

  assign t_o = quo_q[TW-1];

endmodule

`default_nettype wire

// ----- sv/efa_horner.sv -----
// Pipelined Horner evaluation s = t*(a1 + t*(a2 + t*(a3 + t*(a4 + t*a5)))).
// Depends on efa_pkg.
`default_nettype none

module efa_horner (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [efa_pkg::T_W-1:0]   t_i,
  output logic [efa_pkg::S_W-1:0]   s_o
);

  localparam int unsigned NS = efa_pkg::HORNER_STEPS;
  localparam int unsigned AW = efa_pkg::ACC_W;
  localparam int unsigned TW = efa_pkg::T_W;
  localparam int unsigned PW = AW - 1 + TW;

  logic [PW-1:0]          prod_q [NS];
  logic                   nega_q [NS];
  logic [TW-1:0]          ta_q   [NS];
  logic signed [AW-1:0]   acc_q  [NS];
  logic [TW-1:0]          tb_q   [NS];
  logic [efa_pkg::S_W-1:0] s_q;

  for (genvar i = 0; i < NS; i++) begin : g_step
    logic signed [AW-1:0] acc_in;
    logic [TW-1:0]        t_in;
    logic                 neg_w;
    logic [AW-2:0]        m_w;
    logic [PW-1:0]        prod_d;
    logic [AW-1:0]        p_w;
    logic signed [AW-1:0] sp_w;
    logic signed [AW-1:0] acc_d;

    if (i == 0) begin : g_first
      assign acc_in = efa_pkg::K_A5;
      assign t_in   = t_i;
    end else begin : g_next
      assign acc_in = acc_q[i-1];
      assign t_in   = tb_q[i-1];
    end

    // Multiply the magnitude, reapply the sign after rounding
    always_comb begin
      neg_w  = acc_in[AW-1];
      m_w    = neg_w ? (AW-1)'(-acc_in) : (AW-1)'(acc_in);
      prod_d = PW'(m_w) * PW'(t_in);
    end

    always_comb begin
      p_w   = AW'((prod_q[i] + (PW'(1) << 29)) >> 30);
      sp_w  = nega_q[i] ? -$signed(p_w) : $signed(p_w);
      acc_d = efa_pkg::horner_coef(3'(i)) + sp_w;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        prod_q[i] <= prod_d;
        nega_q[i] <= neg_w;
        ta_q[i]   <= t_in;
        acc_q[i]  <= acc_d;
        tb_q[i]   <= ta_q[i];
      end
    end
  end

  // Clamp a negative polynomial to zero
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q <= acc_q[NS-1][AW-1] ? '0 : acc_q[NS-1][efa_pkg::S_W-1:0];
    end
  end

  assign s_o = s_q;

endmodule

`default_nettype wire

// ----- sv/efa_exp.sv -----
// Pipelined exp(-y) in Q30: range reduction by log2(e), then a rounded Taylor
// series with four stages per term. Depends on efa_pkg.
`default_nettype none

module efa_exp (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [efa_pkg::Y_W-1:0]   y_i,
  input  logic                      zero_i,
  output logic [efa_pkg::E_W-1:0]   e_o
);

  localparam int unsigned NT = efa_pkg::EXP_TERMS;
  localparam logic [5:0]  K_LIMIT = 6'd40;
  localparam int unsigned E_W_L = efa_pkg::E_W;

  typedef struct packed {
    logic               zero;
    logic [5:0]         k;
    logic [29:0]        u;
    logic signed [32:0] res;
  } exp_ctl_t;

  logic [63:0] zp_q;
  logic        zero1_q;
  logic [5:0]  k2_q;
  logic [29:0] f2_q;
  logic        zero2_q;
  logic [59:0] up3_q;
  logic [5:0]  k3_q;
  logic        zero3_q;

  exp_ctl_t    ctl_s_q  [NT+1];
  logic [30:0] term_s_q [NT+1];

  exp_ctl_t    c1_q  [NT];
  logic [60:0] p1_q  [NT];
  exp_ctl_t    c2_q  [NT];
  logic [30:0] v2_q  [NT];
  exp_ctl_t    c3_q  [NT];
  logic [30:0] v3_q  [NT];
  logic [65:0] qp3_q [NT];

  logic [E_W_L-1:0] e_q;

  logic [63:0] z_w;
  logic [29:0] u_w;
  logic [30:0] resp_w;
  logic [39:0] rnd_w;
  logic [E_W_L-1:0] e_d;

  // Reduce: z = y*log2(e) split into integer k and fraction f
  always_comb begin
    z_w = (zp_q + (64'd1 << 27)) >> 28;
    u_w = 30'((up3_q + (60'd1 << 29)) >> 30);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zp_q    <= 64'(y_i) * 64'(efa_pkg::K_LOG2E_Q28);
      zero1_q <= zero_i;
      k2_q    <= z_w[35:30];
      f2_q    <= z_w[29:0];
      zero2_q <= zero1_q;
      up3_q   <= 60'(f2_q) * 60'(efa_pkg::K_LN2);
      k3_q    <= k2_q;
      zero3_q <= zero2_q;
      ctl_s_q[0]  <= '{zero: zero3_q, k: k3_q, u: u_w, res: 33'sd1 <<< 30};
      term_s_q[0] <= 31'd1 << 30;
    end
  end

  for (genvar n = 0; n < NT; n++) begin : g_term
    localparam int unsigned  N   = n + 1;
    localparam logic [34:0]  M   = 35'((64'd1 << 34) / 64'(N));
    localparam bit           SUB = (N % 2) == 1;

    logic [30:0]        q0_w;
    logic [34:0]        qn_w;
    logic [34:0]        r_w;
    logic [30:0]        q_w;
    logic signed [32:0] res_d;
    exp_ctl_t           ctl_d;

    // Divide by N through a reciprocal, then fix the quotient once
    always_comb begin
      q0_w  = 31'(qp3_q[n] >> 34);
      qn_w  = 35'(q0_w) * 35'(N);
      r_w   = 35'(v3_q[n]) - qn_w;
      q_w   = (r_w >= 35'(N)) ? q0_w + 31'd1 : q0_w;
      res_d = SUB ? c3_q[n].res - $signed({2'b00, q_w})
                  : c3_q[n].res + $signed({2'b00, q_w});
      ctl_d = c3_q[n];
      ctl_d.res = res_d;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p1_q[n]       <= 61'(term_s_q[n]) * 61'(ctl_s_q[n].u);
        c1_q[n]       <= ctl_s_q[n];
        v2_q[n]       <= 31'((p1_q[n] + (61'(N) << 29)) >> 30);
        c2_q[n]       <= c1_q[n];
        qp3_q[n]      <= 66'(v2_q[n]) * 66'(M);
        v3_q[n]       <= v2_q[n];
        c3_q[n]       <= c2_q[n];
        term_s_q[n+1] <= q_w;
        ctl_s_q[n+1]  <= ctl_d;
      end
    end
  end

  // Scale by 2^-k with round half up; drop to zero out of range
  always_comb begin
    resp_w = ctl_s_q[NT].res[32] ? '0 : ctl_s_q[NT].res[30:0];
    rnd_w  = 40'(resp_w) + (40'd1 << 6'(ctl_s_q[NT].k - 6'd1));
    if (ctl_s_q[NT].zero || (ctl_s_q[NT].k >= K_LIMIT)) begin
      e_d = '0;
    end else if (ctl_s_q[NT].k == 6'd0) begin
      e_d = resp_w;
    end else begin
      e_d = E_W_L'(rnd_w >> ctl_s_q[NT].k);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_q <= e_d;
    end
  end

  assign e_o = e_q;

endmodule

`default_nettype wire

// ----- sv/efa_checker.sv -----
// Port-level checks of the error function block, bound to its top level.
// Depends on error_function_approx_macros.svh and error_function_approx.
`default_nettype none
`include "error_function_approx_macros.svh"

module efa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        arg_valid_i,
  input logic        arg_ready_i,
  input logic        erf_valid_i,
  input logic        erf_ready_i,
  input logic [15:0] erf_value_i
);

  `EFA_ASSERT(a_out_valid_hold, erf_valid_i && !erf_ready_i |=> erf_valid_i, "result word dropped while stalled")
  `EFA_ASSERT(a_out_data_hold, erf_valid_i && !erf_ready_i |=> $stable(erf_value_i), "result word changed while stalled")
  `EFA_ASSERT(a_out_saturated, erf_valid_i |-> erf_value_i != 16'h8000, "result word outside +/-32767")
  `EFA_ASSERT_ALWAYS(a_in_ready_free, !erf_valid_i |-> arg_ready_i, "argument refused with empty output")

endmodule

bind error_function_approx efa_checker u_efa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .arg_valid_i (arg_i.valid),
  .arg_ready_i (arg_i.ready),
  .erf_valid_i (erf_o.valid),
  .erf_ready_i (erf_o.ready),
  .erf_value_i (erf_o.erf_value)
);

`default_nettype wire

// ----- tb/efa_checker.sv -----
// Result checker for the error function block: computes erf in fixed point and
// compares every output word with the oldest expected value. Depends on efa_pkg.
`default_nettype none

module efa_scoreboard (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               arg_valid_i,
  input  logic               arg_ready_i,
  input  logic signed [15:0] arg_x_i,
  input  logic               erf_valid_i,
  input  logic               erf_ready_i,
  input  logic signed [15:0] erf_value_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o,
  output int unsigned        checked_o
);

  localparam logic [63:0] ONE_Q = 64'd1 << efa_pkg::QF;
  localparam logic [63:0] HALF_Q = 64'd1 << (efa_pkg::QF - 1);

  logic signed [15:0] erf_expected_q[$];

  function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                              input logic [63:0] t);
    logic [63:0] m;
    logic [63:0] p;
    m = (a < 0) ? 64'(-a) : 64'(a);
    p = (m * t + HALF_Q) >> efa_pkg::QF;
    return (a < 0) ? -$signed(p) : $signed(p);
  endfunction

  function automatic logic [63:0] exp_neg_q30(input logic [63:0] y);
    logic [63:0] z, k, f, u, term, dv;
    logic signed [63:0] res;
    if (y >= (64'd24 << efa_pkg::QF)) return 0;
    z = (y * 64'(efa_pkg::K_LOG2E_Q28) + (64'd1 << 27)) >> 28;
    k = z >> efa_pkg::QF;
    f = z & (ONE_Q - 1);
    u = (f * 64'(efa_pkg::K_LN2) + HALF_Q) >> efa_pkg::QF;
    term = ONE_Q;
    res = $signed(ONE_Q);
    for (int n = 1; n <= efa_pkg::EXP_TERMS; n++) begin
      dv = 64'(n) << efa_pkg::QF;
      term = (term * u + dv / 2) / dv;
      if (n % 2 == 1) res = res - $signed(term);
      else res = res + $signed(term);
    end
    if (res < 0) res = 0;
    if (k >= 40) return 0;
    if (k == 0) return 64'(res);
    return (64'(res) + (64'd1 << (k - 1))) >> k;
  endfunction

  function automatic logic signed [15:0] erf_of(input logic signed [15:0] x);
    logic neg;
    logic [63:0] mag, px, den, t, s, e, prod;
    logic signed [63:0] acc, r;
    neg = x[15];
    mag = neg ? 64'(17'h10000 - {1'b0, x}) : 64'(x);
    px = (mag * 64'(efa_pkg::K_P) + 64'd2048) >> 12;
    den = ONE_Q + px;
    t = ((64'd1 << 60) + den / 2) / den;
    acc = 64'(efa_pkg::K_A5);
    acc = 64'(efa_pkg::K_A4) + qmul(acc, t);
    acc = 64'(efa_pkg::K_A3) + qmul(acc, t);
    acc = 64'(efa_pkg::K_A2) + qmul(acc, t);
    acc = 64'(efa_pkg::K_A1) + qmul(acc, t);
    acc = qmul(acc, t);
    s = (acc < 0) ? 0 : 64'(acc);
    // Q24 square into Q30
    e = exp_neg_q30((mag * mag) << 6);
    prod = (s * e + HALF_Q) >> efa_pkg::QF;
    r = $signed(ONE_Q) - $signed(prod);
    if (r < 0) r = 0;
    r = $signed((64'(r) + (64'd1 << 14)) >> 15);
    if (r > 32767) r = 32767;
    if (neg) r = -r;
    return 16'(r);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [15:0] want;
    if (!rst_ni) begin
      fail_count_o <= 0;
      checked_o <= 0;
      erf_expected_q.delete();
    end else begin
      if (arg_valid_i && arg_ready_i) erf_expected_q.push_back(erf_of(arg_x_i));
      if (erf_valid_i && erf_ready_i) begin
        checked_o <= checked_o + 1;
        if (erf_expected_q.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected word %0d", erf_value_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = erf_expected_q.pop_front();
          if (want !== erf_value_i) begin
            if (fail_count_o < 10)
              $display("erf_value: expected %0d got %0d", want, erf_value_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = erf_expected_q.size();

endmodule

`default_nettype wire

// ----- tb/tb_error_function_approx.sv -----
// Testbench top: drives argument words with random gaps and stalls the result
// side at random. Depends on efa_pkg, efa_arg_if, efa_erf_if, efa_checker, dut.
`default_nettype none

module tb_error_function_approx;

  localparam int unsigned LIMIT = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b1;
  int unsigned cycle_count = 0;
  int unsigned fail_count, pending, checked;
  int unsigned sent = 0;
  bit          gapless_out = 1'b0;

  efa_arg_if arg_ch ();
  efa_erf_if erf_ch ();

  error_function_approx dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .arg_i  (arg_ch),
    .erf_o  (erf_ch)
  );

  efa_scoreboard u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .arg_valid_i  (arg_ch.valid),
    .arg_ready_i  (arg_ch.ready),
    .arg_x_i      (arg_ch.arg_x),
    .erf_valid_i  (erf_ch.valid),
    .erf_ready_i  (erf_ch.ready),
    .erf_value_i  (erf_ch.erf_value),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Stop a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Stall the result side: draw a random wait before each word, none in gapless stretches.
  initial begin
    int unsigned hold;
    erf_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      hold = gapless_out ? 0 : $urandom_range(0, 4);
      if (hold > 0) begin
        erf_ch.ready <= 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      erf_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!erf_ch.valid) @(posedge clk_i);
    end
  end

  // Present one word, hold until accepted; lower valid only when a gap follows.
  task automatic send_word(input logic signed [15:0] x, input int unsigned gap);
    if (gap > 0) begin
      arg_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    arg_ch.valid <= 1'b1;
    arg_ch.arg_x <= x;
    @(posedge clk_i);
    while (!arg_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
  endtask

  initial begin
    logic signed [15:0] corner[$];
    int unsigned gap;
    logic signed [15:0] x;
    arg_ch.valid = 1'b0;
    arg_ch.arg_x = '0;
    #1 rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Extremes, zero, tiny values, the exp cutoff near |x| = sqrt(24), saturation region
    corner = '{16'sh0000, 16'sh0001, -16'sh0001, 16'sh7FFF, -16'sh8000, -16'sh7FFF,
               16'sd4096, -16'sd4096, 16'sd20066, 16'sd20067, -16'sd20066,
               16'sd8192, 16'sd12288, -16'sd12288, 16'sd16384, 16'sd2048,
               -16'sd2048, 16'sd100, 16'sh5555, -16'sh5556, 16'sh2AAA};
    foreach (corner[i]) send_word(corner[i], 0);

    for (int n = 0; n < 1750; n++) begin
      // Bursts with no idling on either side now and then.
      gapless_out = (n / 200) % 3 == 1;
      gap = gapless_out ? 0 : $urandom_range(0, 4);
      case ($urandom_range(0, 3))
        0: x = 16'($urandom);
        1: x = 16'($signed(17'($urandom_range(0, 16384))) - 17'sd8192);
        2: x = 16'($signed(17'($urandom_range(0, 48000))) - 17'sd24000);
        default: x = 16'($signed(17'($urandom_range(0, 512))) - 17'sd256);
      endcase
      send_word(x, gap);
    end
    arg_ch.valid <= 1'b0;
    gapless_out = 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);

    $display("Sent %0d argument words, %0d results checked against the", sent, checked);
    $display("fixed-point erf prediction, %0d mismatches.", fail_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
